[rtl/assert_macros.svh]
// Assertion macros used by the validator RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, disabled while reset is asserted (active-low reset).
`define NSV_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Checked property, evaluated during reset as well.
`define NSV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

[rtl/nsv_pkg.sv]
// Package for the NMEA sentence validator: character codes, status and kind
// codes, the known sentence types, and the snapshot struct. No dependencies.
`default_nettype none

package nsv_pkg;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_TILDE  = 8'h7E;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_BAD_FRAME  = 3'd1;
    localparam logic [2:0] STATUS_NO_COMMA   = 3'd2;
    localparam logic [2:0] STATUS_BAD_TYPE   = 3'd3;
    localparam logic [2:0] STATUS_FEW_FIELDS = 3'd4;

    localparam logic [2:0] KIND_UNKNOWN = 3'd7;
    localparam int         NUM_TYPES    = 7;

    // Known types, first character in the top byte; index equals kind code.
    localparam logic [39:0] KNOWN_TYPES [NUM_TYPES] = '{
        40'h4750474741,  // GPGGA
        40'h4750474C4C,  // GPGLL
        40'h4750475341,  // GPGSA
        40'h4750475356,  // GPGSV
        40'h4750524D43,  // GPRMC
        40'h4750565447,  // GPVTG
        40'h4750474253   // GPGBS
    };

    localparam logic [7:0] MIN_FIELDS [NUM_TYPES] = '{
        8'd15, 8'd7, 8'd17, 8'd4, 8'd13, 8'd10, 8'd7
    };

    // State captured at the end of one item.
    typedef struct packed {
        logic        done;
        logic        frame_ok;
        logic        comma_seen;
        logic        type_len5;
        logic [39:0] type_chars;
        logic [7:0]  comma_count;
        logic [7:0]  checksum;
    } snap_t;

    // Returns {valid, nibble} for a hex digit of either case.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/nmea_sentence_validator_top.sv]
// Pipeline: a result is registered in the framer snapshot register, then in the
// result register; one result per input item.
// Throughput: one item per cycle while the output is not stalled, set by the
// state update in the framer; both stages advance independently so a stalled
// result still lets one more item in.
// Reset: synchronous, active-low aresetn clears all sentence state and valids.
`default_nettype none
`include "assert_macros.svh"

module nmea_sentence_validator_top import nsv_pkg::*; #(
    parameter int MAX_SENTENCE_LEN = 128
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // input channel: one received character per item
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    // result channel: one result per input item
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_sentence_done,
    output logic [2:0]      m_status,
    output logic [2:0]      m_sentence_kind,
    output logic [7:0]      m_field_count,
    output logic [7:0]      m_computed_checksum
);

    logic       in_accept;
    logic       snap_valid;
    logic       snap_take;
    snap_t      snap;

    logic       c_done;
    logic [2:0] c_status;
    logic [2:0] c_kind;
    logic [7:0] c_fields;
    logic [7:0] c_checksum;

    logic       m_valid_reg,  m_valid_next;
    logic       m_done_reg;
    logic [2:0] m_status_reg;
    logic [2:0] m_kind_reg;
    logic [7:0] m_fields_reg;
    logic [7:0] m_cs_reg;

    // Snapshot moves to the result register whenever that register is free or
    // being drained this cycle.
    assign snap_take = snap_valid && (!m_valid_reg || m_ready);
    assign s_ready   = !snap_valid || snap_take;
    assign in_accept = s_valid && s_ready;

    nsv_framer #(
        .MAX_SENTENCE_LEN(MAX_SENTENCE_LEN)
    ) u_framer (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_data_byte),
        .snap_take  (snap_take),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    nsv_classify u_classify (
        .snap              (snap),
        .sentence_done     (c_done),
        .status            (c_status),
        .sentence_kind     (c_kind),
        .field_count       (c_fields),
        .computed_checksum (c_checksum)
    );

    always_comb begin
        if (snap_take) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, loaded only when a snapshot moves in.
    always_ff @(posedge aclk) begin
        if (snap_take) begin
            m_done_reg   <= c_done;
            m_status_reg <= c_status;
            m_kind_reg   <= c_kind;
            m_fields_reg <= c_fields;
            m_cs_reg     <= c_checksum;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_sentence_done     = m_done_reg;
    assign m_status            = m_status_reg;
    assign m_sentence_kind     = m_kind_reg;
    assign m_field_count       = m_fields_reg;
    assign m_computed_checksum = m_cs_reg;

    // A result that ends no sentence carries all-zero fields.
    `NSV_ASSERT(a_idle_zero, aclk, aresetn,
        (m_valid && !m_sentence_done) |-> (m_status == STATUS_OK &&
        m_sentence_kind == 3'd0 && m_field_count == 8'd0 && m_computed_checksum == 8'd0))
    // An accepted sentence always names a known type.
    `NSV_ASSERT(a_ok_known, aclk, aresetn,
        (m_valid && m_sentence_done && m_status == STATUS_OK) |-> (m_sentence_kind != KIND_UNKNOWN))
    // A finished sentence always reports at least one field.
    `NSV_ASSERT(a_fields_nz, aclk, aresetn, (m_valid && m_sentence_done) |-> (m_field_count != 8'd0))
    // Input is held off only while both stages are occupied and the output stalls.
    `NSV_ASSERT(a_ready_stall, aclk, aresetn,
        !s_ready |-> (snap_valid && m_valid_reg && !m_ready))
    // Reset empties the result register.
    `NSV_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid)

endmodule

`default_nettype wire

[rtl/nsv_framer.sv]
// Sentence framer: running per-sentence state and the snapshot register.
// Depends on nsv_pkg.
`default_nettype none

module nsv_framer import nsv_pkg::*; #(
    parameter int MAX_SENTENCE_LEN = 128
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       snap_take,
    output logic            snap_valid,
    output snap_t           snap
);

    localparam logic [7:0] MAX_LEN = 8'(MAX_SENTENCE_LEN);

    logic [7:0]  byte_count_reg,  byte_count_next;
    logic [7:0]  run_cs_reg,      run_cs_next;
    logic        star_seen_reg,   star_seen_next;
    logic [1:0]  after_star_reg,  after_star_next;
    logic [7:0]  rx_cs_reg,       rx_cs_next;
    logic        frame_bad_reg,   frame_bad_next;
    logic        comma_seen_reg,  comma_seen_next;
    logic [39:0] type_chars_reg,  type_chars_next;
    logic [2:0]  type_len_reg,    type_len_next;
    logic [7:0]  comma_count_reg, comma_count_next;
    logic        snap_valid_reg,  snap_valid_next;
    snap_t       snap_reg,        snap_next;

    logic        is_term;
    logic [4:0]  hex;

    always_comb begin
        is_term          = (in_byte == CHAR_CR) || (in_byte == CHAR_LF);
        hex              = hex_decode(in_byte);
        byte_count_next  = byte_count_reg;
        run_cs_next      = run_cs_reg;
        star_seen_next   = star_seen_reg;
        after_star_next  = after_star_reg;
        rx_cs_next       = rx_cs_reg;
        frame_bad_next   = frame_bad_reg;
        comma_seen_next  = comma_seen_reg;
        type_chars_next  = type_chars_reg;
        type_len_next    = type_len_reg;
        comma_count_next = comma_count_reg;
        snap_next        = '0;

        if (is_term) begin
            if (byte_count_reg != 8'd0) begin
                snap_next.done        = 1'b1;
                snap_next.frame_ok    = !frame_bad_reg && star_seen_reg &&
                                        (after_star_reg == 2'd2) &&
                                        (rx_cs_reg == run_cs_reg);
                snap_next.comma_seen  = comma_seen_reg;
                snap_next.type_len5   = (type_len_reg == 3'd5);
                snap_next.type_chars  = type_chars_reg;
                snap_next.comma_count = comma_count_reg;
                snap_next.checksum    = run_cs_reg;
            end
            byte_count_next  = '0;
            run_cs_next      = '0;
            star_seen_next   = 1'b0;
            after_star_next  = '0;
            rx_cs_next       = '0;
            frame_bad_next   = 1'b0;
            comma_seen_next  = 1'b0;
            type_chars_next  = '0;
            type_len_next    = '0;
            comma_count_next = '0;
        end else begin
            if (byte_count_reg >= MAX_LEN) begin
                frame_bad_next = 1'b1;
            end else begin
                byte_count_next = byte_count_reg + 8'd1;
            end

            if (byte_count_reg == 8'd0) begin
                if (in_byte != CHAR_DOLLAR) begin
                    frame_bad_next = 1'b1;
                end
            end else if (star_seen_reg) begin
                if (after_star_reg != 2'd3) begin
                    after_star_next = after_star_reg + 2'd1;
                end
                if (after_star_next == 2'd3 || !hex[4]) begin
                    frame_bad_next = 1'b1;
                end else begin
                    rx_cs_next = {rx_cs_reg[3:0], hex[3:0]};
                end
            end else if (in_byte == CHAR_STAR) begin
                star_seen_next = 1'b1;
                if (byte_count_reg < 8'd3) begin
                    frame_bad_next = 1'b1;
                end
            end else begin
                run_cs_next = run_cs_reg ^ in_byte;
                if (in_byte < CHAR_SPACE || in_byte > CHAR_TILDE ||
                    in_byte == CHAR_DOLLAR) begin
                    frame_bad_next = 1'b1;
                end
                if (in_byte == CHAR_COMMA) begin
                    comma_seen_next = 1'b1;
                    if (comma_count_reg != 8'hFF) begin
                        comma_count_next = comma_count_reg + 8'd1;
                    end
                end else if (!comma_seen_reg) begin
                    type_chars_next = {type_chars_reg[31:0], in_byte};
                    if (type_len_reg != 3'd6) begin
                        type_len_next = type_len_reg + 3'd1;
                    end
                end
            end
        end

        if (in_accept) begin
            snap_valid_next = 1'b1;
        end else if (snap_take) begin
            snap_valid_next = 1'b0;
        end else begin
            snap_valid_next = snap_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg  <= '0;
            run_cs_reg      <= '0;
            star_seen_reg   <= 1'b0;
            after_star_reg  <= '0;
            rx_cs_reg       <= '0;
            frame_bad_reg   <= 1'b0;
            comma_seen_reg  <= 1'b0;
            type_chars_reg  <= '0;
            type_len_reg    <= '0;
            comma_count_reg <= '0;
            snap_valid_reg  <= 1'b0;
        end else begin
            snap_valid_reg <= snap_valid_next;
            if (in_accept) begin
                byte_count_reg  <= byte_count_next;
                run_cs_reg      <= run_cs_next;
                star_seen_reg   <= star_seen_next;
                after_star_reg  <= after_star_next;
                rx_cs_reg       <= rx_cs_next;
                frame_bad_reg   <= frame_bad_next;
                comma_seen_reg  <= comma_seen_next;
                type_chars_reg  <= type_chars_next;
                type_len_reg    <= type_len_next;
                comma_count_reg <= comma_count_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            snap_reg <= snap_next;
        end
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

endmodule

`default_nettype wire

[rtl/nsv_classify.sv]
// Sentence classifier: type lookup, field count and final status.
// Depends on nsv_pkg.
`default_nettype none

module nsv_classify import nsv_pkg::*; (
    input  wire snap_t  snap,
    output logic        sentence_done,
    output logic [2:0]  status,
    output logic [2:0]  sentence_kind,
    output logic [7:0]  field_count,
    output logic [7:0]  computed_checksum
);

    logic [2:0] kind;
    logic [7:0] fields;

    always_comb begin
        kind = KIND_UNKNOWN;
        if (snap.comma_seen && snap.type_len5) begin
            // Walk down so the lowest matching index wins.
            for (int i = NUM_TYPES - 1; i >= 0; i--) begin
                if (snap.type_chars == KNOWN_TYPES[i]) begin
                    kind = 3'(i);
                end
            end
        end

        fields = (snap.comma_count != 8'hFF) ? snap.comma_count + 8'd1 : 8'hFF;

        if (!snap.frame_ok) begin
            status = STATUS_BAD_FRAME;
        end else if (!snap.comma_seen) begin
            status = STATUS_NO_COMMA;
        end else if (kind == KIND_UNKNOWN) begin
            status = STATUS_BAD_TYPE;
        end else if (fields < MIN_FIELDS[kind]) begin
            status = STATUS_FEW_FIELDS;
        end else begin
            status = STATUS_OK;
        end

        sentence_done     = snap.done;
        sentence_kind     = kind;
        field_count       = fields;
        computed_checksum = snap.checksum;
        if (!snap.done) begin
            status            = STATUS_OK;
            sentence_kind     = 3'd0;
            field_count       = 8'd0;
            computed_checksum = 8'd0;
        end
    end

endmodule

`default_nettype wire

[bench/nmea_sentence_validator_top_tb.sv]
// Self-checking bench for nmea_sentence_validator_top: one byte per item in, one verdict out.
// Depends on nsv_pkg (character, status and kind codes, known types, field minimums).
`timescale 1ns / 1ps

module nmea_sentence_validator_top_tb;
    import nsv_pkg::*;

    localparam int SENT_MAX      = 128;  // MAX_SENTENCE_LEN given to the block
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int MAX_GAP       = 17;   // longest idle stretch per item, either side
    localparam int HOLD_AFTER    = 300;  // result index at which the sink holds off
    localparam int HOLD_CYCLES   = 400;  // length of that hold-off
    localparam int DRAIN_CYCLES  = 8;    // two-stage pipe plus margin
    localparam int FLOOD_COMMAS  = 280;  // enough to saturate field_count
    localparam logic [2:0] KIND_GSV = 3'd3;

    // One verdict as the result channel carries it.
    typedef struct packed {
        logic       done;
        logic [2:0] status;
        logic [2:0] kind;
        logic [7:0] fields;
        logic [7:0] checksum;
    } verdict_t;

    localparam verdict_t QUIET = '0;  // verdict of a byte that ends no sentence

    // Directed table row; "typed" rows carry a hand-written verdict.
    typedef struct {
        logic [7:0] ch;
        bit         typed;
        verdict_t   want;
    } dir_row_t;

    // Ways a random sentence gets broken. FLAW_FLOOD is placed by hand.
    typedef enum int {
        FLAW_NONE, FLAW_SUM, FLAW_NO_STAR, FLAW_EXTRA_HEX, FLAW_NON_HEX, FLAW_CTRL,
        FLAW_DOLLAR, FLAW_STAR2, FLAW_LEAD, FLAW_EARLY_STAR, FLAW_NO_COMMA, FLAW_LONG,
        FLAW_TYPE, FLAW_NOISE, FLAW_FEW, FLAW_FLOOD
    } flaw_t;

    // ------------------------------------------------------------------
    // Clock, reset, DUT
    // ------------------------------------------------------------------
    logic       aclk                = 1'b0;
    logic       aresetn             = 1'b0;
    logic       s_valid             = 1'b0;
    logic [7:0] s_data_byte         = 8'h00;
    logic       m_ready             = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic       m_sentence_done;
    logic [2:0] m_status;
    logic [2:0] m_sentence_kind;
    logic [7:0] m_field_count;
    logic [7:0] m_computed_checksum;

    initial begin
        forever #1 aclk = ~aclk;
    end

    nmea_sentence_validator_top #(
        .MAX_SENTENCE_LEN(SENT_MAX)
    ) u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data_byte        (s_data_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_sentence_done    (m_sentence_done),
        .m_status           (m_status),
        .m_sentence_kind    (m_sentence_kind),
        .m_field_count      (m_field_count),
        .m_computed_checksum(m_computed_checksum)
    );

    // ------------------------------------------------------------------
    // Predictor state: the sentence being framed, cleared at each terminator
    // ------------------------------------------------------------------
    logic [7:0]  sn_len      = '0;  // bytes so far, held at SENT_MAX
    logic [7:0]  sn_xor      = '0;  // XOR between '$' and '*'
    logic        sn_star     = '0;
    logic [1:0]  sn_after    = '0;  // bytes after '*', saturating at 3
    logic [7:0]  sn_rx_sum   = '0;  // hex digits after '*'
    logic        sn_bad      = '0;
    logic        sn_comma    = '0;
    logic [39:0] sn_type     = '0;  // last five type bytes, first one on top
    logic [2:0]  sn_type_len = '0;  // saturating at 6
    logic [7:0]  sn_commas   = '0;

    verdict_t pending_verdicts[$];
    dir_row_t dir_rows[$];

    int  items_sent      = 0;
    int  directed_items  = 0;
    int  results_checked = 0;
    int  mismatch_count  = 0;
    int  sentences_ended = 0;
    int  status_tally[8];
    int  stall_run       = 0;
    int  stall_longest   = 0;
    bit  sender_burst    = 1'b0;
    verdict_t mon_want;

    // {is_hex, value}; folding to lower case catches both letter ranges.
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [7:0] lc;
        lc = b | 8'h20;
        if (b >= 8'h30 && b <= 8'h39) return {1'b1, b[3:0]};
        if (lc >= 8'h61 && lc <= 8'h66) return {1'b1, lc[3:0] + 4'd9};
        return 5'd0;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
        if (n < 4'd10) return 8'h30 + n;
        return (lower ? 8'h61 : 8'h41) + n - 8'd10;
    endfunction

    // Advances the sentence state by one byte and returns the verdict it causes.
    function automatic verdict_t judge_char(input logic [7:0] b);
        verdict_t   r;
        logic [7:0] pos;
        logic [4:0] nib;
        logic [2:0] kind;
        logic [7:0] fields;
        bit         found;
        int         k;
        r = QUIET;
        if (b != CHAR_CR && b != CHAR_LF) begin
            pos = sn_len;
            // overlong: count holds, byte still processed
            if (sn_len >= SENT_MAX) sn_bad = 1'b1;
            else sn_len = sn_len + 8'd1;
            if (pos == 0) begin
                // first byte is only checked against '$'
                if (b != CHAR_DOLLAR) sn_bad = 1'b1;
            end else if (sn_star) begin
                // checksum digits; a second '*' is just a non-hex byte here
                nib = hex_nibble(b);
                if (sn_after != 2'd3) sn_after = sn_after + 2'd1;
                if (sn_after > 2'd2 || !nib[4]) sn_bad = 1'b1;
                else sn_rx_sum = {sn_rx_sum[3:0], nib[3:0]};
            end else if (b == CHAR_STAR) begin
                sn_star = 1'b1;
                if (pos < 3) sn_bad = 1'b1;
            end else begin
                sn_xor = sn_xor ^ b;
                if (b < CHAR_SPACE || b > CHAR_TILDE || b == CHAR_DOLLAR) sn_bad = 1'b1;
                if (b == CHAR_COMMA) begin
                    sn_comma = 1'b1;
                    if (sn_commas != 8'd255) sn_commas = sn_commas + 8'd1;
                end else if (!sn_comma) begin
                    sn_type = {sn_type[31:0], b};
                    if (sn_type_len != 3'd6) sn_type_len = sn_type_len + 3'd1;
                end
            end
        end else if (sn_len != 0) begin
            // terminator of a non-empty sentence; an empty line stays quiet
            kind  = KIND_UNKNOWN;
            found = 1'b0;
            if (sn_comma && sn_type_len == 3'd5) begin
                for (k = 0; k < NUM_TYPES; k++) begin
                    if (!found && sn_type == KNOWN_TYPES[k]) begin
                        kind  = k[2:0];
                        found = 1'b1;
                    end
                end
            end
            fields = (sn_commas != 8'd255) ? sn_commas + 8'd1 : 8'd255;
            r.done     = 1'b1;
            r.kind     = kind;
            r.fields   = fields;
            r.checksum = sn_xor;
            if (sn_bad || !sn_star || sn_after != 2'd2 || sn_rx_sum != sn_xor)
                r.status = STATUS_BAD_FRAME;
            else if (!sn_comma)
                r.status = STATUS_NO_COMMA;
            else if (kind == KIND_UNKNOWN)
                r.status = STATUS_BAD_TYPE;
            else if (fields < MIN_FIELDS[kind])
                r.status = STATUS_FEW_FIELDS;
            else
                r.status = STATUS_OK;
            sentences_ended++;
            status_tally[r.status]++;
            sn_len = '0; sn_xor = '0; sn_star = '0; sn_after = '0; sn_rx_sum = '0;
            sn_bad = '0; sn_comma = '0; sn_type = '0; sn_type_len = '0; sn_commas = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: random gap per item, then hold valid until accepted
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] ch, input bit typed, input verdict_t want);
        int       gap;
        verdict_t v;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= ch;
        do @(posedge aclk); while (!s_ready);
        // item accepted at this edge; predictor always advances
        v = judge_char(ch);
        pending_verdicts = {pending_verdicts, typed ? want : v};
        items_sent++;
    endtask

    function automatic void add_row(input logic [7:0] ch, input bit typed, input verdict_t want);
        dir_row_t row;
        row.ch    = ch;
        row.typed = typed;
        row.want  = want;
        dir_rows = {dir_rows, row};
    endfunction

    function automatic void add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) add_row(s[i], 1'b0, QUIET);
    endfunction

    function automatic logic [7:0] field_char();
        logic [7:0] c;
        do c = 8'($urandom_range(8'h20, 8'h7E));
        while (c == CHAR_DOLLAR || c == CHAR_STAR || c == CHAR_COMMA);
        return c;
    endfunction

    // Mostly well-formed sentences of every type with random field content;
    // the rest broken in one way, or bare noise.
    task automatic send_random_sentence(input int serial);
        logic [7:0]  body[$];
        logic [7:0]  sum;
        logic [7:0]  c;
        logic [39:0] tname;
        logic [4:0]  nib;
        flaw_t       flaw;
        int          kind, nfield, flen, i, j, bad_digit;
        flaw = ($urandom_range(0, 99) < 55) ? FLAW_NONE
                                             : flaw_t'($urandom_range(1, FLAW_FEW));
        if (serial == 3 || serial == 20) flaw = FLAW_FLOOD;

        if (flaw == FLAW_NOISE) begin
            // raw bytes, terminators included, may leave a partial sentence
            j = $urandom_range(1, 12);
            for (i = 0; i < j; i++) send_char(8'($urandom_range(0, 255)), 1'b0, QUIET);
            return;
        end

        // type field
        kind = $urandom_range(0, NUM_TYPES);
        if (kind < NUM_TYPES) begin
            tname = KNOWN_TYPES[kind];
            for (i = 4; i >= 0; i--) body = {body, tname[i*8 +: 8]};
            nfield = MIN_FIELDS[kind] + $urandom_range(0, 3) - 1;
            if (flaw == FLAW_FEW) nfield = MIN_FIELDS[kind] - $urandom_range(1, 3);
        end else begin
            j = $urandom_range(1, 8);
            for (i = 0; i < j; i++) body = {body, 8'($urandom_range(8'h41, 8'h5A))};
            nfield = $urandom_range(1, 6);
        end
        if (flaw == FLAW_TYPE) begin
            // near miss: one short, one long, or one letter off
            case ($urandom_range(0, 2))
                0: void'(body.pop_back());
                1: body = {body, 8'h58};
                default: begin
                    i = $urandom_range(0, body.size() - 1);
                    body[i] = body[i] + 8'd1;
                end
            endcase
        end
        if (flaw == FLAW_NO_COMMA) nfield = 1;

        // comma separated fields
        for (i = 1; i < nfield; i++) begin
            body = {body, CHAR_COMMA};
            flen = $urandom_range(0, 3);
            for (j = 0; j < flen; j++) body = {body, field_char()};
        end
        if (flaw == FLAW_LONG) begin
            while (body.size() < SENT_MAX + 10)
                body = {body, ($urandom_range(0, 3) == 0) ? CHAR_COMMA : field_char()};
        end
        if (flaw == FLAW_FLOOD) begin
            for (i = 0; i < FLOOD_COMMAS; i++) body = {body, CHAR_COMMA};
        end
        if (flaw == FLAW_CTRL) begin
            do c = 8'($urandom_range(0, 255));
            while ((c >= CHAR_SPACE && c <= CHAR_TILDE) || c == CHAR_CR || c == CHAR_LF);
            body.insert($urandom_range(0, body.size()), c);
        end
        if (flaw == FLAW_DOLLAR) body.insert($urandom_range(0, body.size()), CHAR_DOLLAR);
        if (flaw == FLAW_EARLY_STAR) begin
            // '*' lands at position 1 or 2
            body.delete();
            if ($urandom_range(0, 1)) body = {body, 8'($urandom_range(8'h41, 8'h5A))};
        end

        sum = 8'h00;
        foreach (body[i]) sum = sum ^ body[i];
        if (flaw == FLAW_SUM) sum = sum ^ 8'($urandom_range(1, 255));

        // lead byte
        if (flaw == FLAW_LEAD) begin
            do c = 8'($urandom_range(0, 255));
            while (c == CHAR_DOLLAR || c == CHAR_CR || c == CHAR_LF);
            send_char(c, 1'b0, QUIET);
        end else begin
            send_char(CHAR_DOLLAR, 1'b0, QUIET);
        end
        foreach (body[i]) send_char(body[i], 1'b0, QUIET);

        // checksum tail, hex digits in either case
        if (flaw != FLAW_NO_STAR) begin
            send_char(CHAR_STAR, 1'b0, QUIET);
            bad_digit = (flaw == FLAW_NON_HEX) ? $urandom_range(0, 1) : -1;
            for (i = 0; i < 2; i++) begin
                if (i == bad_digit) begin
                    do begin
                        c   = 8'($urandom_range(0, 255));
                        nib = hex_nibble(c);
                    end while (nib[4] || c == CHAR_CR || c == CHAR_LF);
                end else begin
                    c = hex_char((i == 0) ? sum[7:4] : sum[3:0], 1'($urandom_range(0, 1)));
                end
                send_char(c, 1'b0, QUIET);
            end
            if (flaw == FLAW_EXTRA_HEX)
                send_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))),
                          1'b0, QUIET);
            if (flaw == FLAW_STAR2) send_char(CHAR_STAR, 1'b0, QUIET);
        end

        // CR, LF, or CR LF (the LF then is an empty line)
        case ($urandom_range(0, 2))
            0: send_char(CHAR_CR, 1'b0, QUIET);
            1: send_char(CHAR_LF, 1'b0, QUIET);
            default: begin
                send_char(CHAR_CR, 1'b0, QUIET);
                send_char(CHAR_LF, 1'b0, QUIET);
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result sink: random stalls, burst stretches, and one long hold-off
    // that backs the pipe up into the input while the sender keeps offering
    // ------------------------------------------------------------------
    initial begin : result_sink
        int taken;
        int gap;
        bit burst;
        taken = 0;
        burst = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (taken % 50 == 0) burst = ($urandom_range(0, 3) == 0);
            if (taken == HOLD_AFTER) gap = HOLD_CYCLES;
            else gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted verdict against the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("MISMATCH @%0t: %s got %0d want %0d", $time, what, got, want);
    endtask

    always @(posedge aclk) begin
        // track how long the input sits blocked (hold-off shows up here)
        if (s_valid && !s_ready) stall_run++;
        else stall_run = 0;
        if (stall_run > stall_longest) stall_longest = stall_run;

        if (aresetn && m_valid && m_ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with nothing pending", 1, 0);
            end else begin
                mon_want = pending_verdicts.pop_front();
                results_checked++;
                if (m_sentence_done !== mon_want.done)
                    report_mismatch("sentence_done", m_sentence_done, mon_want.done);
                if (m_status !== mon_want.status)
                    report_mismatch("status", m_status, mon_want.status);
                if (m_sentence_kind !== mon_want.kind)
                    report_mismatch("sentence_kind", m_sentence_kind, mon_want.kind);
                if (m_field_count !== mon_want.fields)
                    report_mismatch("field_count", m_field_count, mon_want.fields);
                if (m_computed_checksum !== mon_want.checksum)
                    report_mismatch("computed_checksum", m_computed_checksum,
                                    mon_want.checksum);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus: directed table, then random sentences, then drain
    // ------------------------------------------------------------------
    initial begin : stimulus
        int serial;
        foreach (status_tally[serial]) status_tally[serial] = 0;

        // empty line straight after reset: a quiet verdict, no sentence ended
        add_row(CHAR_CR, 1'b1, QUIET);
        // byte extremes: bad lead byte, then a non-printable one
        add_row(8'h00, 1'b1, QUIET);
        add_row(8'hFF, 1'b1, QUIET);
        add_row(CHAR_LF, 1'b1, verdict_t'{1'b1, STATUS_BAD_FRAME, KIND_UNKNOWN, 8'd1, 8'hFF});
        // good frame, no comma
        add_text("$AB*03");
        add_row(CHAR_CR, 1'b1, verdict_t'{1'b1, STATUS_NO_COMMA, KIND_UNKNOWN, 8'd1, 8'h03});
        // shortest accepted sentence: GSV at its field minimum
        add_text("$GPGSV,,,*79");
        add_row(CHAR_LF, 1'b1, verdict_t'{1'b1, STATUS_OK, KIND_GSV, 8'd4, 8'h79});

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[serial])
            send_char(dir_rows[serial].ch, dir_rows[serial].typed, dir_rows[serial].want);
        directed_items = items_sent;

        serial = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            sender_burst = ($urandom_range(0, 3) == 0);
            send_random_sentence(serial);
            serial++;
        end
        s_valid <= 1'b0;

        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d bytes (%0d directed) in %0d random sentences; %0d verdicts checked",
                 items_sent, directed_items, serial, results_checked);
        $display("Ended %0d: ok %0d, frame %0d, no comma %0d, type %0d, few %0d; stall %0d cyc",
                 sentences_ended, status_tally[STATUS_OK], status_tally[STATUS_BAD_FRAME],
                 status_tally[STATUS_NO_COMMA], status_tally[STATUS_BAD_TYPE],
                 status_tally[STATUS_FEW_FIELDS], stall_longest);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("Timeout with %0d verdicts outstanding", pending_verdicts.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule
